FILE: hw/rtl/mfd_pkg.sv
// Shared constants and types for the MQTT frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

   // Largest remaining length and largest frame size accepted, in bytes.
   localparam int MAX_LEN   = 255;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 14;
   localparam int SUM_W     = LEN_W + 1;
   localparam int CNT_W     = $clog2(MAX_LEN + 2);

   // Remaining-length byte layout: 7 payload bits, bit 7 flags another byte.
   localparam int LEN_BITS  = 7;
   localparam int CONT_BIT  = 7;
   localparam int LEN_SHIFT = 7;

   localparam logic [SUM_W-1:0] LEN_SAT = SUM_W'((2 ** LEN_W) - 1);

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic [BYTE_W-1:0] frame_position;
      logic [BYTE_W-1:0] packet_header;
      logic [BYTE_W-1:0] header_length;
      logic [LEN_W-1:0]  remaining_length;
      logic              frame_done;
      logic              frame_dropped;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mqtt_frame_deframer_top.sv
// Top level of the MQTT frame deframer: byte stream in, per-byte frame results out.
`timescale 1ns / 1ps
`default_nettype none

// Delimits MQTT control packets in a received byte stream, one byte per
// transaction. The first byte of a frame is the packet header; the length
// bytes that follow build the remaining length (the first gives its low 7
// bits, every later one adds its low 7 bits shifted left by 7); then exactly
// that many body bytes follow. Every input transaction yields exactly one
// result transaction echoing the byte with its frame position, the header,
// the header length and the remaining length decoded so far (saturated at
// 16383). tlast marks the byte that completes a packet; tuser flags a frame
// dropped for a length above MAX_LEN, or for running past MAX_LEN bytes.
// After either the decoder is back to expecting a packet header. Rate: one
// byte per clock sustained while rsp_tready holds high; each result is
// registered (the byte sits in the input register and is decoded into the
// result register once that register can take it). Ready propagates from
// rsp_tready back through both registers in the same cycle.
module mqtt_frame_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [7:0] byte_out, [15:8] frame_position,
                                         // [23:16] packet_header, [31:24] header_length,
                                         // [45:32] remaining_length, [47:46] zero
   output logic             rsp_tlast,   // frame_done
   output logic             rsp_tuser    // [0] frame_dropped
);
   import mfd_pkg::*;

   logic              item_valid;
   logic [BYTE_W-1:0] item_data;
   logic              load_ready;
   logic              fire;
   result_type        result;
   result_type        rsp_data;

   // Advance a byte from the input register only when the result slot frees.
   assign fire = item_valid && load_ready;

   mfd_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (fire),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   mfd_frame_core u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (item_data),
      .result    (result)
   );

   mfd_result_reg u_result_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid),
      .load_ready (load_ready),
      .load_data  (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   // Pack the result, first field in the lowest bits.
   assign rsp_tdata = {2'b00,
                       rsp_data.remaining_length,
                       rsp_data.header_length,
                       rsp_data.packet_header,
                       rsp_data.frame_position,
                       rsp_data.byte_out};
   assign rsp_tlast = rsp_data.frame_done;
   assign rsp_tuser = rsp_data.frame_dropped;

   // A frame is never both completed and dropped.
   a_done_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tlast && rsp_tuser))
      else $error("frame both completed and dropped");

   // A completed frame spans its header bytes plus its body exactly.
   a_done_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_data.frame_position ==
          (rsp_data.header_length + rsp_data.remaining_length[BYTE_W-1:0])))
      else $error("completed frame length mismatch");

   // A byte held in the input register is not lost while decode is stalled.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !fire) |=> (item_valid && $stable(item_data)))
      else $error("stalled input byte lost");

endmodule

`default_nettype wire

FILE: hw/rtl/mfd_input_reg.sv
// Input register stage: holds one received byte until the decoder takes it.
`timescale 1ns / 1ps
`default_nettype none

module mfd_input_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [mfd_pkg::BYTE_W-1:0] req_tdata,
   input  wire logic                      take,
   output logic                           item_valid,
   output logic [mfd_pkg::BYTE_W-1:0]     item_data
);
   import mfd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff,  data_in;

   // Accept whenever the slot is empty or is being drained this cycle.
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         data_in  = req_tdata;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mfd_frame_core.sv
// Frame decoder: packet state and the per-byte result computation.
`timescale 1ns / 1ps
`default_nettype none

module mfd_frame_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      fire,
   input  wire logic [mfd_pkg::BYTE_W-1:0] data_byte,
   output mfd_pkg::result_type            result
);
   import mfd_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN_FIRST,
      PH_LEN_MORE,
      PH_BODY
   } phase_type;

   phase_type         phase_ff,  phase_in;
   logic [LEN_W-1:0]  left_ff,   left_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] offset_ff, offset_in;
   logic [LEN_W-1:0]  total_ff,  total_in;

   logic [CNT_W-1:0]  count_inc;
   logic [SUM_W-1:0]  sum;
   logic [LEN_W-1:0]  left_dec;
   logic              done;
   logic              dropped;

   always_comb begin
      count_inc = count_ff + CNT_W'(1);
      phase_in  = phase_ff;
      left_in   = left_ff;
      header_in = header_ff;
      offset_in = offset_ff;
      sum       = {1'b0, total_ff};
      left_dec  = left_ff;
      done      = 1'b0;
      dropped   = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            header_in = data_byte;
            phase_in  = PH_LEN_FIRST;
         end
         PH_LEN_FIRST, PH_LEN_MORE: begin
            if (phase_ff == PH_LEN_FIRST) begin
               sum = SUM_W'(data_byte[LEN_BITS-1:0]);
            end else begin
               sum = {1'b0, total_ff}
                   + (SUM_W'(data_byte[LEN_BITS-1:0]) << LEN_SHIFT);
            end
            if (sum > SUM_W'(MAX_LEN)) begin
               dropped = 1'b1;
            end else if (!data_byte[CONT_BIT]) begin
               offset_in = count_inc[BYTE_W-1:0];
               left_in   = sum[LEN_W-1:0];
               if (sum == '0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_BODY;
               end
            end else begin
               phase_in = PH_LEN_MORE;
            end
         end
         PH_BODY: begin
            if (left_ff != '0) begin
               left_dec = left_ff - LEN_W'(1);
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               done = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Oversize frame wins over completion.
      if (count_inc > CNT_W'(MAX_LEN)) begin
         dropped = 1'b1;
         done    = 1'b0;
      end

      total_in = sum[LEN_W-1:0];
      count_in = count_inc;

      result.byte_out         = data_byte;
      result.frame_position   = count_inc[BYTE_W-1:0];
      result.packet_header    = header_in;
      result.header_length    = offset_in;
      result.remaining_length = (sum > LEN_SAT) ? LEN_SAT[LEN_W-1:0] : sum[LEN_W-1:0];
      result.frame_done       = done;
      result.frame_dropped    = dropped;

      // Return to idle after a completed or discarded frame.
      if (done || dropped) begin
         phase_in  = PH_IDLE;
         left_in   = '0;
         count_in  = '0;
         header_in = '0;
         offset_in = '0;
         total_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         left_ff   <= '0;
         count_ff  <= '0;
         header_ff <= '0;
         offset_ff <= '0;
         total_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
         header_ff <= header_in;
         offset_ff <= offset_in;
         total_ff  <= total_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mfd_result_reg.sv
// Result register: holds one decoded result until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module mfd_result_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load_valid,
   output logic                     load_ready,
   input  wire mfd_pkg::result_type load_data,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output mfd_pkg::result_type      rsp_data
);
   import mfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff,  data_in;

   assign load_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

`default_nettype wire

FILE: tb/mqtt_frame_deframer_checker.sv
// Checker for the MQTT frame deframer: predicts each result and compares it.
`timescale 1ns / 1ps

module mqtt_frame_deframer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,   // [7:0] byte_out, [15:8] frame_position,
                                         // [23:16] packet_header, [31:24] header_length,
                                         // [45:32] remaining_length, [47:46] zero
   input  wire logic        rsp_tlast,   // frame_done
   input  wire logic        rsp_tuser,   // [0] frame_dropped
   output int               mismatch_count,
   output int               open_results
);

   localparam int unsigned LEN_CEILING = (2 ** mfd_pkg::LEN_W) - 1;

   typedef enum logic [2:0] {
      PARSE_HEADER,
      PARSE_LEN_FIRST,
      PARSE_LEN_MORE,
      PARSE_BODY
   } parse_phase_type;

   parse_phase_type   phase        = PARSE_HEADER;
   logic [13:0]       bytes_left   = '0;
   logic [8:0]        frame_count  = '0;
   logic [7:0]        header_byte  = '0;
   logic [7:0]        body_offset  = '0;
   int unsigned       total_length = 0;

   mfd_pkg::result_type frame_results[$];
   int fault_tally = 0;
   int open_tally  = 0;

   assign mismatch_count = fault_tally;
   assign open_results   = open_tally;

   function automatic void clear_frame_state();
      phase        = PARSE_HEADER;
      bytes_left   = '0;
      frame_count  = '0;
      header_byte  = '0;
      body_offset  = '0;
      total_length = 0;
   endfunction

   // Advance the parser by one byte and return the result it should produce.
   function automatic mfd_pkg::result_type decode_stream_byte(input logic [7:0] b);
      mfd_pkg::result_type r;
      logic                done;
      logic                dropped;
      int unsigned         shown_len;
      done        = 1'b0;
      dropped     = 1'b0;
      frame_count = frame_count + 9'd1;
      case (phase)
         PARSE_HEADER: begin
            header_byte = b;
            phase       = PARSE_LEN_FIRST;
         end
         PARSE_LEN_FIRST, PARSE_LEN_MORE: begin
            if (phase == PARSE_LEN_FIRST)
               total_length = int'(b[6:0]);
            else
               total_length = total_length + (int'(b[6:0]) << 7);
            if (total_length > mfd_pkg::MAX_LEN) begin
               dropped = 1'b1;
            end else if (!b[7]) begin
               body_offset = frame_count[7:0];
               bytes_left  = total_length[13:0];
               if (total_length == 0)
                  done = 1'b1;
               else
                  phase = PARSE_BODY;
            end else begin
               phase = PARSE_LEN_MORE;
            end
         end
         default: begin
            if (bytes_left > 0)
               bytes_left = bytes_left - 14'd1;
            if (bytes_left == 0)
               done = 1'b1;
         end
      endcase
      // running past the size limit wins over completion
      if (frame_count > mfd_pkg::MAX_LEN) begin
         dropped = 1'b1;
         done    = 1'b0;
      end
      shown_len = (total_length > LEN_CEILING) ? LEN_CEILING : total_length;
      r.byte_out         = b;
      r.frame_position   = frame_count[7:0];
      r.packet_header    = header_byte;
      r.header_length    = body_offset;
      r.remaining_length = shown_len[13:0];
      r.frame_done       = done;
      r.frame_dropped    = dropped;
      if (done || dropped)
         clear_frame_state();
      return r;
   endfunction

   // Queue an expected result behind the ones still outstanding.
   function automatic void append_expected(input mfd_pkg::result_type r);
      frame_results = {frame_results, r};
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fault_tally++;
      end
   endtask

   always @(posedge clock) begin
      mfd_pkg::result_type want;
      if (reset) begin
         clear_frame_state();
         frame_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_results.size() == 0) begin
               $error("unexpected result transaction: byte_out %0d", rsp_tdata[7:0]);
               fault_tally++;
            end else begin
               want = frame_results.pop_front();
               compare_field("byte_out",         want.byte_out,         rsp_tdata[7:0]);
               compare_field("frame_position",   want.frame_position,   rsp_tdata[15:8]);
               compare_field("packet_header",    want.packet_header,    rsp_tdata[23:16]);
               compare_field("header_length",    want.header_length,    rsp_tdata[31:24]);
               compare_field("remaining_length", want.remaining_length, rsp_tdata[45:32]);
               compare_field("frame_done",       want.frame_done,       rsp_tlast);
               compare_field("frame_dropped",    want.frame_dropped,    rsp_tuser);
            end
         end
         if (req_tvalid && req_tready)
            append_expected(decode_stream_byte(req_tdata));
      end
      open_tally <= frame_results.size();
   end

endmodule

FILE: tb/mqtt_frame_deframer_top_test.sv
// Testbench top for the MQTT frame deframer: stimulus, ready pressure and verdict.
`timescale 1ns / 1ps

module mqtt_frame_deframer_top_test;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [7:0] byte_out, [15:8] frame_position,
                                      // [23:16] packet_header, [31:24] header_length,
                                      // [45:32] remaining_length, [47:46] zero
   logic        rsp_tlast;            // frame_done
   logic        rsp_tuser;            // [0] frame_dropped

   int mismatch_count;
   int open_results;

   // Byte count actually handed to the block, and the knobs for source idling.
   int bytes_sent    = 0;
   int req_gap_odds  = 0;     // 0: no gaps, N: a gap before about one byte in N
   bit steady_tail   = 1'b0;  // set for the last stretch: no idling on either side

   // 12 ns period.
   always #6 clock = ~clock;

   mqtt_frame_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   mqtt_frame_deframer_checker frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .open_results   (open_results)
   );

   // Offer one byte and hold it until the transaction completes. Optionally
   // drop valid for a random burst first. Returns at the accepting edge, so
   // the next call drives valid in the same step without lowering it first.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send a packet: header, remaining-length bytes, then body_count body bytes.
   // pad inserts continuation bytes that add nothing to the length; a length
   // under 128 with padding ends with a zero length byte. A body_count below
   // len leaves the packet unfinished so the next bytes land in its body.
   task automatic send_packet(input logic [7:0] hdr, input int len, input int pad,
                              input int body_count);
      push_byte(hdr);
      if (len < 128 && pad == 0) begin
         push_byte(8'(len));
      end else begin
         push_byte({1'b1, 7'(len)});
         repeat (pad) push_byte(8'h80);
         push_byte({1'b0, 7'(len >> 7)});
      end
      repeat (body_count) push_byte(8'($urandom));
   endtask

   // Receiver side: random bursts of backpressure, none in the final stretch.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!steady_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // Hard stop in case the handshakes hang.
   initial begin
      #10_000_000;
      $display("mqtt_frame_deframer_top_test: errors");
      $finish;
   end

   initial begin
      int pick;
      int len;
      int pad;
      logic [7:0] hdr;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, no source gaps.
      // zero-length packet, all-zero header
      push_byte(8'h00); push_byte(8'h00);
      // all-ones header, two body bytes at the extremes
      push_byte(8'hFF); push_byte(8'h02); push_byte(8'h00); push_byte(8'hFF);
      // length too large: 1 + 256
      push_byte(8'h30); push_byte(8'h81); push_byte(8'h02);
      // length too large with every length bit set: 16383
      push_byte(8'h10); push_byte(8'hFF); push_byte(8'h7F);
      // zero length through a padded encoding
      push_byte(8'h82); push_byte(8'h80); push_byte(8'h00);
      // one-byte body, then the next byte opens a new frame right after completion
      push_byte(8'h20); push_byte(8'h01); push_byte(8'hAA);
      push_byte(8'h55); push_byte(8'h00);

      // Size limits: a frame of exactly MAX_LEN bytes completes, one byte more drops.
      send_packet(8'($urandom), 252, 0, 252);
      send_packet(8'($urandom), 253, 0, 253);
      // Length bytes that never end run the frame past the limit.
      push_byte(8'($urandom));
      repeat (255) push_byte(8'h80);

      // Random traffic: mostly well-formed packets, some broken or noisy.
      while (bytes_sent < 1700) begin
         if (bytes_sent >= 1450) begin
            steady_tail  = 1'b1;
            req_gap_odds = 0;
         end else begin
            req_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 3;
         end
         hdr  = 8'($urandom);
         pick = $urandom_range(0, 99);
         pad  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
         if (pick < 66) begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 127);
            send_packet(hdr, len, pad, len);
         end else if (pick < 68) begin
            len = $urandom_range(128, 255);
            send_packet(hdr, len, pad, len);
         end else if (pick < 69) begin
            push_byte(hdr);
            repeat (255) push_byte(8'h80);
         end else if (pick < 80) begin
            // second length byte pushes the length over the limit
            push_byte(hdr);
            push_byte({1'b1, 7'($urandom)});
            push_byte({1'($urandom), 7'($urandom_range(2, 127))});
         end else if (pick < 90) begin
            len = $urandom_range(2, 40);
            send_packet(hdr, len, pad, $urandom_range(0, len - 1));
         end else begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // Drain: let the count settle, wait for every result, then a few more cycles.
      repeat (2) @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && open_results == 0)
         $display("mqtt_frame_deframer_top_test: clean");
      else
         $display("mqtt_frame_deframer_top_test: errors");
      $finish;
   end

endmodule
